// File: hw/rtl/ipv4p_pkg.sv
`timescale 1ns / 1ps
// ipv4p_pkg: parser state codes, radix codes, range limits and character classes
// for the dotted ipv4 address parser; no dependencies

package ipv4p_pkg;

  localparam int unsigned ChWidth   = 8;
  localparam int unsigned AddrWidth = 32;
  localparam int unsigned NumDone   = 3;

  localparam logic [AddrWidth-1:0] Lim1Part = 32'h0000_00ff;
  localparam logic [AddrWidth-1:0] Lim2Part = 32'h00ff_ffff;
  localparam logic [AddrWidth-1:0] Lim3Part = 32'h0000_ffff;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_ZERO   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_TRAIL  = 5'b01000,
    PH_ERR    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic                 ok;
    logic [AddrWidth-1:0] addr;
  } outcome_t;

  localparam logic [ChWidth-1:0] ChNul   = 8'h00;
  localparam logic [ChWidth-1:0] ChZero  = 8'h30;
  localparam logic [ChWidth-1:0] ChEight = 8'h38;
  localparam logic [ChWidth-1:0] ChNine  = 8'h39;
  localparam logic [ChWidth-1:0] ChDot   = 8'h2e;
  localparam logic [ChWidth-1:0] ChLowX  = 8'h78;
  localparam logic [ChWidth-1:0] ChUpX   = 8'h58;

  function automatic logic is_dec(input logic [ChWidth-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_space(input logic [ChWidth-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // hex digit value in the low nibble, bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_digit(input logic [ChWidth-1:0] c);
    logic [ChWidth-1:0] d;
    d = 8'h00;
    if (is_dec(c)) begin
      return {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      d = {5'b0, c[2:0]} + 8'd9;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

// File: hw/rtl/ipv4_dotted_address_parser.sv
`timescale 1ns / 1ps
// ipv4_dotted_address_parser: byte-stream parser for dotted ipv4 addresses
// depends on ipv4p_pkg
// throughput: one byte per cycle, except that a nul byte stalls behind an untaken result
// result: registered, it appears in the cycle after the nul byte is accepted
// the result register frees the input side: bytes flow on while a result waits,
// and only a nul byte stalls behind an untaken result
// reset: synchronous, clears parser state and the result register

module ipv4_dotted_address_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ipv4p_pkg::ChWidth-1:0]   ch,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            valid_res,
  output logic [ipv4p_pkg::AddrWidth-1:0] address
);

  import ipv4p_pkg::*;

  // parser state
  phase_t               phase, phase_next;
  radix_t               radix, radix_next;
  logic [AddrWidth-1:0] accum, accum_next;
  logic                 seen_digit, seen_next;
  logic [1:0]           part_count, part_count_next;
  logic [7:0]           done_parts [NumDone];
  outcome_t             outcome;

  // per-byte decode
  logic                 accept;
  logic                 do_digits;
  logic                 part_wr;
  logic                 finish_now;
  radix_t               radix_eff;
  logic                 seen_eff;
  logic [4:0]           hx;
  logic [AddrWidth-1:0] mul10;
  logic [AddrWidth-1:0] fin_value;
  logic                 fin_ok;
  outcome_t             res;

  // a nul byte needs the result register free; other bytes never stall
  assign in_ready = !out_valid || out_ready || (ch != ChNul);
  assign accept   = in_valid && in_ready;

  // after a leading zero a non-x byte is handled as an octal digit byte
  assign radix_eff = (phase == PH_ZERO) ? RX_OCT : radix;
  assign seen_eff  = (phase == PH_ZERO) ? 1'b1 : seen_digit;
  assign hx        = hex_digit(ch);
  assign mul10     = (accum << 3) + (accum << 1);

  // value and range check for the form given by the number of finished parts
  always_comb begin
    fin_value = accum;
    fin_ok    = seen_eff;
    case (part_count)
      2'd0: begin
      end
      2'd1: begin
        if (accum > Lim2Part) fin_ok = 1'b0;
        fin_value = accum | {done_parts[0], 24'h0};
      end
      2'd2: begin
        if (accum > Lim3Part) fin_ok = 1'b0;
        fin_value = accum | {done_parts[0], done_parts[1], 16'h0};
      end
      default: begin
        if (accum > Lim1Part) fin_ok = 1'b0;
        fin_value = accum | {done_parts[0], done_parts[1], done_parts[2], 8'h0};
      end
    endcase
  end

  always_comb begin
    phase_next      = phase;
    radix_next      = radix;
    accum_next      = accum;
    seen_next       = seen_digit;
    part_count_next = part_count;
    do_digits       = 1'b0;
    part_wr         = 1'b0;
    finish_now      = 1'b0;

    case (phase)
      PH_START: begin
        if (!is_dec(ch)) begin
          phase_next = PH_ERR;
        end else begin
          accum_next = {{(AddrWidth-4){1'b0}}, ch[3:0]};
          radix_next = RX_DEC;
          if (ch == ChZero) begin
            seen_next  = 1'b0;
            phase_next = PH_ZERO;
          end else begin
            seen_next  = 1'b1;
            phase_next = PH_DIGITS;
          end
        end
      end
      PH_ZERO: begin
        if ((ch == ChLowX) || (ch == ChUpX)) begin
          radix_next = RX_HEX;
          seen_next  = 1'b0;
          phase_next = PH_DIGITS;
        end else begin
          radix_next = RX_OCT;
          seen_next  = 1'b1;
          phase_next = PH_DIGITS;
          do_digits  = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digits = 1'b1;
      end
      default: begin
        // trailing bytes and error: ignored up to the nul
      end
    endcase

    if (do_digits) begin
      if (is_dec(ch)) begin
        if ((radix_eff == RX_OCT) && (ch >= ChEight)) begin
          phase_next = PH_ERR;
        end else begin
          case (radix_eff)
            RX_HEX:  accum_next = {accum[AddrWidth-5:0], hx[3:0]};
            RX_OCT:  accum_next = {accum[AddrWidth-4:0], 3'b0} + {28'h0, ch[3:0]};
            default: accum_next = mul10 + {28'h0, ch[3:0]};
          endcase
          seen_next = 1'b1;
        end
      end else if ((radix_eff == RX_HEX) && hx[4]) begin
        accum_next = {accum[AddrWidth-5:0], hx[3:0]};
        seen_next  = 1'b1;
      end else if (ch == ChDot) begin
        if ((part_count == 2'd3) || (accum > Lim1Part)) begin
          phase_next = PH_ERR;
        end else begin
          part_wr         = 1'b1;
          part_count_next = part_count + 2'd1;
          phase_next      = PH_START;
        end
      end else if ((ch == ChNul) || is_space(ch)) begin
        finish_now = 1'b1;
        phase_next = PH_TRAIL;
      end else begin
        phase_next = PH_ERR;
      end
    end

    // result for a nul: fresh finish, else any outcome held since whitespace
    if (finish_now) begin
      res.ok   = fin_ok;
      res.addr = fin_ok ? fin_value : '0;
    end else if (phase == PH_TRAIL) begin
      res = outcome;
    end else begin
      res.ok   = 1'b0;
      res.addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      radix      <= RX_DEC;
      accum      <= '0;
      seen_digit <= 1'b0;
      part_count <= 2'd0;
      outcome    <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a new result replaces one taken in the same cycle
      if (accept && (ch == ChNul)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (ch == ChNul) begin
          // end of string: deliver and return to the reset state
          phase      <= PH_START;
          radix      <= RX_DEC;
          accum      <= '0;
          seen_digit <= 1'b0;
          part_count <= 2'd0;
          outcome    <= '0;
        end else begin
          phase      <= phase_next;
          radix      <= radix_next;
          accum      <= accum_next;
          seen_digit <= seen_next;
          part_count <= part_count_next;
          if (finish_now) begin
            outcome.ok   <= fin_ok;
            outcome.addr <= fin_ok ? fin_value : '0;
          end
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept && (ch == ChNul)) begin
      valid_res <= res.ok;
      address   <= res.addr;
    end
    if (accept && part_wr) begin
      done_parts[part_count] <= accum[7:0];
    end
  end

  // a failed parse always reports a zero address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> address == '0)
    else $error("invalid result carries a non-zero address");

  // every accepted nul produces a result transaction
  assert property (@(posedge clk) disable iff (rst)
    accept && (ch == ChNul) |=> out_valid)
    else $error("nul accepted without a result");

  // the parser is back in its reset state after a nul
  assert property (@(posedge clk) disable iff (rst)
    accept && (ch == ChNul) |=> (phase == PH_START) && (part_count == 2'd0) && !seen_digit)
    else $error("parser state not cleared after end of string");

  // dotted parts never exceed three
  assert property (@(posedge clk) disable iff (rst)
    part_wr && accept |-> part_count != 2'd3)
    else $error("fourth dotted part recorded");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for ipv4_dotted_address_parser; feeds address strings
// a byte at a time and checks every result against a built-in predictor
// depends on ipv4p_pkg and ipv4_dotted_address_parser

module testbench;
  import ipv4p_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int TargetBytes = 1800;
  localparam int LongHold = 400;

  typedef logic [ChWidth-1:0] byte_q[$];

  // scoreboard: mirrors the parser state and queues the outcome of every string
  class addr_scoreboard;
    phase_t               ph;
    logic [AddrWidth-1:0] acc;
    radix_t               rdx;
    bit                   got_digit;
    logic [7:0]           parts[NumDone];
    logic [1:0]           nparts;
    bit                   held_ok;
    logic [AddrWidth-1:0] held_addr;
    outcome_t             expected[$];
    int                   mismatches;
    int                   results_seen;

    function new();
      clear();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void clear();
      ph = PH_START;
      acc = '0;
      rdx = RX_DEC;
      got_digit = 1'b0;
      foreach (parts[i]) parts[i] = '0;
      nparts = '0;
      held_ok = 1'b0;
      held_addr = '0;
    endfunction

    function int waiting();
      return expected.size();
    endfunction

    // one byte inside the digits of a part
    function void digit_byte(logic [ChWidth-1:0] c);
      bit                   num;
      bit                   hexc;
      logic [3:0]           hv;
      logic [AddrWidth-1:0] v;
      bit                   ok;
      num = (c >= ChZero) && (c <= ChNine);
      hexc = 1'b0;
      hv = c[3:0];
      if (c >= "a" && c <= "f") begin
        hexc = 1'b1;
        hv = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
        hexc = 1'b1;
        hv = 4'(c - "A" + 8'd10);
      end
      if (num) begin
        if (rdx == RX_OCT && c >= ChEight) begin
          ph = PH_ERR;
          return;
        end
        if (rdx == RX_HEX) acc = {acc[27:0], hv};
        else acc = acc * ((rdx == RX_OCT) ? 32'd8 : 32'd10) + 32'(c - ChZero);
        got_digit = 1'b1;
      end else if (rdx == RX_HEX && hexc) begin
        acc = {acc[27:0], hv};
        got_digit = 1'b1;
      end else if (c == ChDot) begin
        if (nparts == 2'd3 || acc > Lim1Part) begin
          ph = PH_ERR;
          return;
        end
        parts[nparts] = acc[7:0];
        nparts++;
        ph = PH_START;
      end else if (c == ChNul || c == " " || (c >= 8'h09 && c <= 8'h0d)) begin
        // end of number: range check the last part against the form
        v = acc;
        ok = got_digit;
        case (nparts)
          2'd0: ;
          2'd1: begin
            if (v > Lim2Part) ok = 1'b0;
            v |= {parts[0], 24'h0};
          end
          2'd2: begin
            if (v > Lim3Part) ok = 1'b0;
            v |= {parts[0], parts[1], 16'h0};
          end
          default: begin
            if (v > Lim1Part) ok = 1'b0;
            v |= {parts[0], parts[1], parts[2], 8'h0};
          end
        endcase
        held_ok = ok;
        held_addr = ok ? v : '0;
        ph = PH_TRAIL;
      end else begin
        ph = PH_ERR;
      end
    endfunction

    function void note_byte(logic [ChWidth-1:0] c);
      outcome_t r;
      case (ph)
        PH_START: begin
          if (!(c >= ChZero && c <= ChNine)) begin
            ph = PH_ERR;
          end else begin
            acc = 32'(c - ChZero);
            rdx = RX_DEC;
            got_digit = (c != ChZero);
            ph = (c == ChZero) ? PH_ZERO : PH_DIGITS;
          end
        end
        PH_ZERO: begin
          if (c == ChLowX || c == ChUpX) begin
            rdx = RX_HEX;
            got_digit = 1'b0;
            ph = PH_DIGITS;
          end else begin
            rdx = RX_OCT;
            got_digit = 1'b1;
            ph = PH_DIGITS;
            digit_byte(c);
          end
        end
        PH_DIGITS: digit_byte(c);
        default: ;
      endcase
      if (c == ChNul) begin
        r.ok = (ph == PH_TRAIL) && held_ok;
        r.addr = (ph == PH_TRAIL) ? held_addr : '0;
        expected.push_back(r);
        clear();
      end
    endfunction

    function void check_result(logic ok, logic [AddrWidth-1:0] addr);
      outcome_t want;
      results_seen++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing expected: valid_res %0b address %08h",
                   results_seen, ok, addr);
        return;
      end
      want = expected.pop_front();
      if (ok !== want.ok || addr !== want.addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: valid_res exp %0b got %0b, address exp %08h got %08h",
                   results_seen, want.ok, ok, want.addr, addr);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ChWidth-1:0]   ch = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 valid_res;
  logic [AddrWidth-1:0] address;

  addr_scoreboard sb = new();

  int cycles = 0;
  int sent_count = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit hold_req = 1'b0;

  ipv4_dotted_address_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .address   (address)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** ipv4_dotted_address_parser: FAILED **");
      $finish;
    end
  end

  // both channels are observed at the rising edge, before any register moves
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(valid_res, address);
      if (in_valid && in_ready) sb.note_byte(ch);
    end
  end

  // one byte per transaction; a random gap ahead of it, with calm stretches between
  task automatic send_byte(input logic [ChWidth-1:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    ch = b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(ChNul);
  endtask

  task automatic send_seq(input byte_q q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one number in decimal, octal or hex, upper or lower case
  function automatic byte_q fmt_num(input logic [AddrWidth-1:0] v);
    byte_q      d;
    logic [AddrWidth-1:0] t;
    logic [3:0] nib;
    bit         upper;
    t = v;
    upper = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: begin
        do begin
          d.push_front(ChZero + 8'(t % 10));
          t = t / 10;
        end while (t != 0);
        // a few extra digits now and then may push the part out of range
        if ($urandom_range(0, 15) == 0)
          repeat ($urandom_range(1, 4)) d.push_back(ChZero + 8'($urandom_range(0, 9)));
      end
      1: begin
        do begin
          d.push_front(ChZero + {5'b0, t[2:0]});
          t = t >> 3;
        end while (t != 0);
        d.push_front(ChZero);
      end
      default: begin
        if ($urandom_range(0, 15) == 0) begin
          // prefix with no digits
          d.push_back(ChZero);
          d.push_back(upper ? ChUpX : ChLowX);
        end else begin
          do begin
            nib = t[3:0];
            d.push_front(nib < 4'd10 ? ChZero + {4'h0, nib}
                                     : (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10);
            t = t >> 4;
          end while (t != 0);
          repeat ($urandom_range(0, 2)) d.push_front(ChZero);
          d.push_front($urandom_range(0, 1) ? ChUpX : ChLowX);
          d.push_front(ChZero);
        end
      end
    endcase
    return d;
  endfunction

  // well-formed string of one to four parts, mostly in range, sometimes mutated
  function automatic byte_q make_address();
    byte_q                q;
    int                   np;
    int                   p;
    logic [AddrWidth-1:0] v;
    np = $urandom_range(1, 4);
    for (int i = 0; i < np; i++) begin
      if (i > 0) q.push_back(ChDot);
      if (i < np - 1) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 4095) : $urandom_range(0, 255);
      end else begin
        v = $urandom;
        if ($urandom_range(0, 7) != 0) begin
          case (np)
            2: v = v & Lim2Part;
            3: v = v & Lim3Part;
            4: v = v & Lim1Part;
            default: ;
          endcase
        end
      end
      q = {q, fmt_num(v)};
    end
    // whitespace ends the number, what follows is junk up to the nul
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, 5);
      q.push_back(p == 0 ? 8'h20 : 8'(8'h08 + p));
      repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      p = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 3))
        0: q[p] = 8'($urandom_range(1, 255));
        1: q.delete(p);
        2: q.insert(p, 8'($urandom_range(1, 255)));
        default: q.insert(p, ChDot);
      endcase
    end
    q.push_back(ChNul);
    return q;
  endfunction

  // receiver: random stall before each result, calm stretches, one long hold on request
  initial begin : receiver
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        stall = LongHold;
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        stall = recv_calm ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    byte_q q;
    bit    held;
    bit    paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty string, odd radix forms, range limits, bad bytes
    send_text("");
    send_text("0x.1");
    send_text("0x");
    send_text("08");
    send_text("1.2.3.4.");
    send_text("256.1");
    send_text("1.2.65536");
    send_text("0XfF.0377.255 z");
    send_text("1..2");
    send_text("4294967296");
    send_byte(8'hff);
    send_byte(ChNul);
    drain();

    // random: mostly well-formed strings, some pure noise
    while (sent_count < TargetBytes) begin
      if ($urandom_range(0, 9) == 0) begin
        q.delete();
        repeat ($urandom_range(0, 12)) q.push_back(8'($urandom_range(1, 255)));
        q.push_back(ChNul);
      end else begin
        q = make_address();
      end
      send_seq(q);
      // long hold on the result side while bytes keep coming, so a nul backs up
      if (!held && sent_count > TargetBytes / 3) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent_count > 2 * TargetBytes / 3) begin
        paused = 1'b1;
        drain();
      end
    end

    in_valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("** ipv4_dotted_address_parser: PASSED **");
    end else begin
      $display("** ipv4_dotted_address_parser: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ipv4p_pkg.sv
hw/rtl/ipv4_dotted_address_parser.sv
tb/testbench.sv
